// File: src/pl_pkg.sv
// ----------------------------------------------------------------------------
// pl_pkg
// Types and codes shared by the positional list engine: command and status
// codes, sequencer states and the input and result word layouts.
// ----------------------------------------------------------------------------
package pl_pkg;

    typedef enum logic [2:0] {
        CMD_READ        = 3'd0,
        CMD_INSERT_AT   = 3'd1,
        CMD_REMOVE_AT   = 3'd2,
        CMD_INSERT_HEAD = 3'd3,
        CMD_INSERT_TAIL = 3'd4,
        CMD_REMOVE_HEAD = 3'd5,
        CMD_REMOVE_TAIL = 3'd6
    } cmd_t;

    typedef enum logic [1:0] {
        ST_DONE    = 2'd0,
        ST_IGNORED = 2'd1,
        ST_FULL    = 2'd2
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_UP,
        S_PUT,
        S_DN,
        S_OUT
    } state_t;

    localparam logic signed [31:0] READ_MISS = -32'sd1;

    typedef struct packed {
        logic [2:0]         command;
        logic [4:0]         position;
        logic signed [31:0] value_in;
    } in_word_t;

    typedef struct packed {
        logic signed [31:0] read_value;
        logic [1:0]         status;
        logic [4:0]         entry_count;
    } out_word_t;

endpackage

// File: src/positional_list_engine.sv
// ----------------------------------------------------------------------------
// positional_list_engine
// Packed list of signed 32-bit values kept in one synchronous RAM.
// A read or a refused word goes straight to OUT; an insert moves the entries
// at p and above up in UP, then writes in PUT; a remove moves the entries
// above p down in DN; the RAM moves one entry per cycle during a shift.
// Throughput: one word at a time; the next word is accepted the cycle after
// the result is loaded, even if that result is still waiting on m_ready.
// Reset: synchronous, active low; clears the count, the sequencer and the
// output valid. RAM contents are not cleared.
// ----------------------------------------------------------------------------
module positional_list_engine #(
    parameter int MAX_ENTRIES = 16
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  pl_pkg::in_word_t   s_data,
    output logic               m_valid,
    input  logic               m_ready,
    output pl_pkg::out_word_t  m_data
);
    import pl_pkg::*;

    localparam int CW = $clog2(MAX_ENTRIES + 1);
    localparam int AW = $clog2(MAX_ENTRIES);
    localparam int W  = (CW > 5) ? CW : 5;

    logic signed [31:0] mem [MAX_ENTRIES];
    logic signed [31:0] rd_data_reg;

    state_t             state_reg, state_next;
    logic [CW-1:0]      count_reg, count_next;
    logic [CW-1:0]      cur_reg, cur_next;
    logic [CW-1:0]      pos_reg, pos_next;
    logic signed [31:0] val_reg, val_next;
    status_t            status_reg, status_next;
    logic signed [31:0] rv_reg, rv_next;
    logic               rv_mem_reg, rv_mem_next;
    logic               m_valid_reg;
    out_word_t          m_data_reg;

    // Decode of the word at the input, against the current count.
    cmd_t               cmd;
    logic [W-1:0]       pos_w, cnt_w, cnt_m1_w, p_w, p_p1_w;
    status_t            dec_status;
    state_t             dec_state;
    logic signed [31:0] dec_rv;
    logic               dec_rv_mem, dec_rd_en, dec_dec_count;
    logic [AW-1:0]      dec_rd_addr;
    logic [CW-1:0]      dec_cur;

    logic [CW-1:0]      cur_m1, cur_m2, cur_p2;

    logic               rd_en, wr_en, out_load;
    logic [AW-1:0]      rd_addr, wr_addr;
    logic signed [31:0] wr_data;

    assign cmd      = cmd_t'(s_data.command);
    assign pos_w    = W'(s_data.position);
    assign cnt_w    = W'(count_reg);
    assign cnt_m1_w = cnt_w - W'(1);
    assign p_p1_w   = p_w + W'(1);
    assign cur_m1   = cur_reg - CW'(1);
    assign cur_m2   = cur_reg - CW'(2);
    assign cur_p2   = cur_reg + CW'(2);

    always_comb begin
        p_w           = '0;
        dec_status    = ST_IGNORED;
        dec_state     = S_OUT;
        dec_rv        = '0;
        dec_rv_mem    = 1'b0;
        dec_rd_en     = 1'b0;
        dec_rd_addr   = '0;
        dec_cur       = '0;
        dec_dec_count = 1'b0;
        unique case (cmd)
            CMD_READ: begin
                if (pos_w < cnt_w) begin
                    dec_status  = ST_DONE;
                    dec_rv_mem  = 1'b1;
                    dec_rd_en   = 1'b1;
                    dec_rd_addr = pos_w[AW-1:0];
                end else begin
                    dec_rv = READ_MISS;
                end
            end
            CMD_INSERT_AT, CMD_INSERT_HEAD, CMD_INSERT_TAIL: begin
                priority case (cmd)
                    CMD_INSERT_AT:   p_w = pos_w;
                    CMD_INSERT_HEAD: p_w = '0;
                    default:         p_w = cnt_w;
                endcase
                if (p_w > cnt_w) begin
                    dec_status = ST_IGNORED;
                end else if (cnt_w >= W'(MAX_ENTRIES)) begin
                    dec_status = ST_FULL;
                end else begin
                    dec_status = ST_DONE;
                    if (p_w == cnt_w) begin
                        dec_state = S_PUT;
                    end else begin
                        // Entries from the tail down to p move up one place.
                        dec_state   = S_UP;
                        dec_rd_en   = 1'b1;
                        dec_rd_addr = cnt_m1_w[AW-1:0];
                        dec_cur     = count_reg;
                    end
                end
            end
            CMD_REMOVE_AT, CMD_REMOVE_HEAD, CMD_REMOVE_TAIL: begin
                priority case (cmd)
                    CMD_REMOVE_AT:   p_w = pos_w;
                    CMD_REMOVE_HEAD: p_w = '0;
                    default:         p_w = cnt_m1_w;
                endcase
                if (count_reg == '0 || p_w >= cnt_w) begin
                    dec_status = ST_IGNORED;
                end else begin
                    dec_status = ST_DONE;
                    if (p_p1_w < cnt_w) begin
                        // Entries above p move down one place.
                        dec_state   = S_DN;
                        dec_rd_en   = 1'b1;
                        dec_rd_addr = p_p1_w[AW-1:0];
                        dec_cur     = p_w[CW-1:0];
                    end else begin
                        dec_dec_count = 1'b1;
                    end
                end
            end
            default: begin
                dec_status = ST_IGNORED;
            end
        endcase
    end

    // Next state and datapath registers.
    always_comb begin
        state_next  = state_reg;
        count_next  = count_reg;
        cur_next    = cur_reg;
        pos_next    = pos_reg;
        val_next    = val_reg;
        status_next = status_reg;
        rv_next     = rv_reg;
        rv_mem_next = rv_mem_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    state_next  = dec_state;
                    cur_next    = dec_cur;
                    pos_next    = p_w[CW-1:0];
                    val_next    = s_data.value_in;
                    status_next = dec_status;
                    rv_next     = dec_rv;
                    rv_mem_next = dec_rv_mem;
                    if (dec_dec_count) begin
                        count_next = count_reg - CW'(1);
                    end
                end
            end
            S_UP: begin
                if (cur_m1 > pos_reg) begin
                    cur_next = cur_m1;
                end else begin
                    state_next = S_PUT;
                end
            end
            S_PUT: begin
                count_next = count_reg + CW'(1);
                state_next = S_OUT;
            end
            S_DN: begin
                if (cur_p2 < count_reg) begin
                    cur_next = cur_reg + CW'(1);
                end else begin
                    count_next = count_reg - CW'(1);
                    state_next = S_OUT;
                end
            end
            S_OUT: begin
                if (!m_valid_reg || m_ready) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // RAM controls, handshake and output load.
    always_comb begin
        s_ready  = 1'b0;
        rd_en    = 1'b0;
        rd_addr  = '0;
        wr_en    = 1'b0;
        wr_addr  = cur_reg[AW-1:0];
        wr_data  = rd_data_reg;
        out_load = 1'b0;
        unique case (state_reg)
            S_IDLE: begin
                s_ready = 1'b1;
                rd_en   = s_valid && dec_rd_en;
                rd_addr = dec_rd_addr;
            end
            S_UP: begin
                wr_en = 1'b1;
                if (cur_m1 > pos_reg) begin
                    rd_en   = 1'b1;
                    rd_addr = cur_m2[AW-1:0];
                end
            end
            S_PUT: begin
                wr_en   = 1'b1;
                wr_addr = pos_reg[AW-1:0];
                wr_data = val_reg;
            end
            S_DN: begin
                wr_en = 1'b1;
                if (cur_p2 < count_reg) begin
                    rd_en   = 1'b1;
                    rd_addr = cur_p2[AW-1:0];
                end
            end
            S_OUT: begin
                out_load = !m_valid_reg || m_ready;
            end
            default: begin
                s_ready = 1'b0;
            end
        endcase
    end

    // A shift reads the address two places ahead of the one it writes, so the
    // two addresses never meet.
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            count_reg <= count_next;
            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        cur_reg    <= cur_next;
        pos_reg    <= pos_next;
        val_reg    <= val_next;
        status_reg <= status_next;
        rv_reg     <= rv_next;
        rv_mem_reg <= rv_mem_next;
        if (out_load) begin
            m_data_reg.read_value  <= rv_mem_reg ? rd_data_reg : rv_reg;
            m_data_reg.status      <= status_reg;
            m_data_reg.entry_count <= 5'(count_reg);
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule
